// ===== rtl/irpd_pkg.sv =====
// irpd_pkg: shared types and constants of the ir pulse decoder duty stepper
// used by irpd_front, irpd_back, the top unit and the bench; depends on nothing
`default_nettype none
package irpd_pkg;

  localparam int unsigned QueueDepth = 2;

  localparam int unsigned CfgAddrW = 5;
  localparam int unsigned CfgDataW = 32;

  localparam logic [2:0] RegStartLow     = 3'd0;
  localparam logic [2:0] RegStartHigh    = 3'd1;
  localparam logic [2:0] RegBitThreshold = 3'd2;
  localparam logic [2:0] RegCodeServoUp  = 3'd3;
  localparam logic [2:0] RegCodeServoDn  = 3'd4;
  localparam logic [2:0] RegCodeLedUp    = 3'd5;
  localparam logic [2:0] RegLedTop       = 3'd6;
  localparam logic [2:0] RegAdjustStep   = 3'd7;

  localparam logic [15:0] StartLowRst     = 16'd29;
  localparam logic [15:0] StartHighRst    = 16'd32;
  localparam logic [15:0] BitThresholdRst = 16'd15;
  localparam logic [15:0] CodeServoUpRst  = 16'd752;
  localparam logic [15:0] CodeServoDnRst  = 16'd2800;
  localparam logic [15:0] CodeLedUpRst    = 16'd3280;
  localparam logic [7:0]  LedTopRst       = 8'd99;
  localparam logic [3:0]  AdjustStepRst   = 4'd5;

  localparam logic [7:0] ServoMax   = 8'd250;
  localparam logic [7:0] ServoMin   = 8'd50;
  localparam logic [7:0] ServoReset = 8'd150;
  localparam logic [7:0] LatchCount = 8'd11;
  localparam logic [8:0] LedMaxSeen = 9'd270;

  typedef struct packed {
    logic [15:0] start_low;
    logic [15:0] start_high;
    logic [15:0] bit_threshold;
  } front_cfg_t;

  typedef struct packed {
    logic [15:0] code_servo_up;
    logic [15:0] code_servo_down;
    logic [15:0] code_led_up;
    logic [7:0]  led_top;
    logic [3:0]  adjust_step;
  } back_cfg_t;

  typedef struct packed {
    logic        code_done;
    logic [15:0] code_value;
  } code_evt_t;

  typedef struct packed {
    logic [7:0]  servo_duty;
    logic [8:0]  led_duty;
    logic        code_done;
    logic [15:0] code_value;
  } result_t;

endpackage
`default_nettype wire

// ===== rtl/irpd_fifo.sv =====
// irpd_fifo: small register queue that parts the stages of the decoder
// depends on no package items
`default_nettype none
module irpd_fifo #(
  parameter int unsigned WIDTH = 17,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rdata,
  output logic                  empty
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PtrW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0]  count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CntFull);
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrLast) ? '0 : wr_ptr_r + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrLast) ? '0 : rd_ptr_r + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= wdata;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CntFull) else $error("queue count beyond depth");
  a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
    (do_push && !do_pop) |=> (count_r == $past(count_r) + CntW'(1)))
    else $error("queue count missed a push");
  a_count_down: assert property (@(posedge clk) disable iff (!rst_n)
    (do_pop && !do_push) |=> (count_r == $past(count_r) - CntW'(1)))
    else $error("queue count missed a pop");
`endif

endmodule
`default_nettype wire

// ===== rtl/irpd_front.sv =====
// irpd_front: interval measurement, pulse classification and bit assembly
// depends on irpd_pkg
`default_nettype none
module irpd_front (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  accept,
  input  wire logic [15:0]           edge_stamp,
  input  wire irpd_pkg::front_cfg_t  cfg,
  output irpd_pkg::code_evt_t        evt
);

  logic [15:0] last_stamp_r, last_stamp_nxt;
  logic [15:0] shift_bits_r, shift_bits_nxt;
  logic [7:0]  bit_count_r, bit_count_nxt;
  logic [15:0] interval;
  logic        is_start;

  assign interval = edge_stamp - last_stamp_r;
  assign is_start = (interval > cfg.start_low) && (interval < cfg.start_high);

  always_comb begin
    last_stamp_nxt = edge_stamp;
    shift_bits_nxt = shift_bits_r;
    bit_count_nxt  = bit_count_r;
    priority if (is_start) begin
      shift_bits_nxt = '0;
      bit_count_nxt  = '0;
    end else if (interval > cfg.bit_threshold) begin
      shift_bits_nxt = (shift_bits_r | 16'd1) << 1;
      bit_count_nxt  = bit_count_r + 8'd1;
    end else if (interval < cfg.bit_threshold) begin
      shift_bits_nxt = shift_bits_r << 1;
      bit_count_nxt  = bit_count_r + 8'd1;
    end
  end

  always_comb begin
    evt.code_done  = (bit_count_nxt == irpd_pkg::LatchCount);
    evt.code_value = evt.code_done ? shift_bits_nxt : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_stamp_r <= '0;
      shift_bits_r <= '0;
      bit_count_r  <= '0;
    end else if (accept) begin
      last_stamp_r <= last_stamp_nxt;
      shift_bits_r <= shift_bits_nxt;
      bit_count_r  <= bit_count_nxt;
    end
  end

`ifndef SYNTHESIS
  a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && is_start) |=> (bit_count_r == '0 && shift_bits_r == '0))
    else $error("start interval did not clear the bit state");
  a_low_bit: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !shift_bits_r[0]) else $error("shift register low bit set");
  a_stamp_kept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (last_stamp_r == $past(edge_stamp)))
    else $error("edge stamp not kept");
`endif

endmodule
`default_nettype wire

// ===== rtl/irpd_back.sv =====
// irpd_back: command execution on the servo and led duty levels
// depends on irpd_pkg
`default_nettype none
module irpd_back (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 accept,
  input  wire irpd_pkg::code_evt_t  evt,
  input  wire irpd_pkg::back_cfg_t  cfg,
  output irpd_pkg::result_t         res
);

  logic [7:0] servo_r, servo_nxt;
  logic [8:0] led_r, led_nxt;
  logic [8:0] servo_sum;
  logic [7:0] servo_sub;
  logic [7:0] servo_dn;
  logic [8:0] step9;

  assign step9     = {5'd0, cfg.adjust_step};
  assign servo_sum = {1'b0, servo_r} + step9;
  assign servo_sub = (servo_r >= {4'd0, cfg.adjust_step}) ?
                     servo_r - {4'd0, cfg.adjust_step} : '0;
  assign servo_dn  = (servo_r >= irpd_pkg::ServoMin) ? servo_sub : servo_r;

  always_comb begin
    servo_nxt = servo_r;
    led_nxt   = led_r;
    if (evt.code_done) begin
      priority if (evt.code_value == cfg.code_servo_up) begin
        if (servo_r <= irpd_pkg::ServoMax) begin
          servo_nxt = (servo_sum > {1'b0, irpd_pkg::ServoMax}) ?
                      irpd_pkg::ServoMax : servo_sum[7:0];
        end else begin
          servo_nxt = irpd_pkg::ServoMax;
        end
      end else if (evt.code_value == cfg.code_servo_down) begin
        servo_nxt = (servo_dn < irpd_pkg::ServoMin) ? irpd_pkg::ServoMin : servo_dn;
      end else if (evt.code_value == cfg.code_led_up) begin
        if (led_r <= {1'b0, cfg.led_top}) begin
          led_nxt = led_r + step9;
        end
      end else begin
        led_nxt = (led_r >= step9) ? led_r - step9 : '0;
      end
    end
  end

  always_comb begin
    res.servo_duty = servo_nxt;
    res.led_duty   = led_nxt;
    res.code_done  = evt.code_done;
    res.code_value = evt.code_value;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      servo_r <= irpd_pkg::ServoReset;
      led_r   <= '0;
    end else if (accept) begin
      servo_r <= servo_nxt;
      led_r   <= led_nxt;
    end
  end

`ifndef SYNTHESIS
  a_servo_range: assert property (@(posedge clk) disable iff (!rst_n)
    (servo_r >= irpd_pkg::ServoMin) && (servo_r <= irpd_pkg::ServoMax))
    else $error("servo level out of range");
  a_led_range: assert property (@(posedge clk) disable iff (!rst_n)
    led_r <= irpd_pkg::LedMaxSeen) else $error("led level out of range");
  a_idle_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !evt.code_done) |=> ($stable(servo_r) && $stable(led_r)))
    else $error("duty moved without a code");
`endif

endmodule
`default_nettype wire

// ===== rtl/ir_pulse_decoder_duty_stepper_unit.sv =====
// ir pulse decoder duty stepper: an accepted item is registered in the middle queue,
// then in the output queue, ready to pop; one item per cycle while results are popped,
// set by the front bit assembly loop (subtract, compare, shift) and two-entry queues
// synchronous active-low reset: duties 150/0, bit state cleared, registers to defaults
// depends on irpd_pkg, irpd_front, irpd_fifo, irpd_back
`default_nettype none
module ir_pulse_decoder_duty_stepper_unit #(
  parameter int unsigned QUEUE_DEPTH = irpd_pkg::QueueDepth
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_push,
  output logic                               in_full,
  input  wire logic [15:0]                   in_edge_stamp,
  output logic                               out_empty,
  input  wire logic                          out_pop,
  output logic [7:0]                         out_servo_duty,
  output logic [8:0]                         out_led_duty,
  output logic                               out_code_done,
  output logic [15:0]                        out_code_value,
  input  wire logic                          cfg_psel,
  input  wire logic                          cfg_penable,
  input  wire logic                          cfg_pwrite,
  input  wire logic [irpd_pkg::CfgAddrW-1:0] cfg_paddr,
  input  wire logic [irpd_pkg::CfgDataW-1:0] cfg_pwdata,
  output logic [irpd_pkg::CfgDataW-1:0]      cfg_prdata,
  output logic                               cfg_pready
);

  localparam int unsigned EvtW = $bits(irpd_pkg::code_evt_t);
  localparam int unsigned ResW = $bits(irpd_pkg::result_t);

  irpd_pkg::front_cfg_t fcfg_r;
  irpd_pkg::back_cfg_t  bcfg_r;
  irpd_pkg::code_evt_t  front_evt, mid_evt;
  irpd_pkg::result_t    back_res, out_res;
  logic [2:0]           cfg_idx;
  logic                 cfg_wr;
  logic                 in_accept, mid_full, mid_empty, out_full, mid_pop;
  logic [EvtW-1:0]      mid_rdata;
  logic [ResW-1:0]      out_rdata;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[4:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fcfg_r.start_low       <= irpd_pkg::StartLowRst;
      fcfg_r.start_high      <= irpd_pkg::StartHighRst;
      fcfg_r.bit_threshold   <= irpd_pkg::BitThresholdRst;
      bcfg_r.code_servo_up   <= irpd_pkg::CodeServoUpRst;
      bcfg_r.code_servo_down <= irpd_pkg::CodeServoDnRst;
      bcfg_r.code_led_up     <= irpd_pkg::CodeLedUpRst;
      bcfg_r.led_top         <= irpd_pkg::LedTopRst;
      bcfg_r.adjust_step     <= irpd_pkg::AdjustStepRst;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        irpd_pkg::RegStartLow:     fcfg_r.start_low       <= cfg_pwdata[15:0];
        irpd_pkg::RegStartHigh:    fcfg_r.start_high      <= cfg_pwdata[15:0];
        irpd_pkg::RegBitThreshold: fcfg_r.bit_threshold   <= cfg_pwdata[15:0];
        irpd_pkg::RegCodeServoUp:  bcfg_r.code_servo_up   <= cfg_pwdata[15:0];
        irpd_pkg::RegCodeServoDn:  bcfg_r.code_servo_down <= cfg_pwdata[15:0];
        irpd_pkg::RegCodeLedUp:    bcfg_r.code_led_up     <= cfg_pwdata[15:0];
        irpd_pkg::RegLedTop:       bcfg_r.led_top         <= cfg_pwdata[7:0];
        irpd_pkg::RegAdjustStep:   bcfg_r.adjust_step     <= cfg_pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg_prdata = '0;
    unique case (cfg_idx)
      irpd_pkg::RegStartLow:     cfg_prdata[15:0] = fcfg_r.start_low;
      irpd_pkg::RegStartHigh:    cfg_prdata[15:0] = fcfg_r.start_high;
      irpd_pkg::RegBitThreshold: cfg_prdata[15:0] = fcfg_r.bit_threshold;
      irpd_pkg::RegCodeServoUp:  cfg_prdata[15:0] = bcfg_r.code_servo_up;
      irpd_pkg::RegCodeServoDn:  cfg_prdata[15:0] = bcfg_r.code_servo_down;
      irpd_pkg::RegCodeLedUp:    cfg_prdata[15:0] = bcfg_r.code_led_up;
      irpd_pkg::RegLedTop:       cfg_prdata[7:0]  = bcfg_r.led_top;
      irpd_pkg::RegAdjustStep:   cfg_prdata[3:0]  = bcfg_r.adjust_step;
      default: ;
    endcase
  end

  assign in_full   = mid_full;
  assign in_accept = in_push && !mid_full;
  assign mid_pop   = !mid_empty && !out_full;
  assign mid_evt   = irpd_pkg::code_evt_t'(mid_rdata);
  assign out_res   = irpd_pkg::result_t'(out_rdata);

  irpd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (in_accept),
    .edge_stamp (in_edge_stamp),
    .cfg        (fcfg_r),
    .evt        (front_evt)
  );

  irpd_fifo #(
    .WIDTH (EvtW),
    .DEPTH (QUEUE_DEPTH)
  ) u_mid_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push),
    .wdata (front_evt),
    .full  (mid_full),
    .pop   (mid_pop),
    .rdata (mid_rdata),
    .empty (mid_empty)
  );

  irpd_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (mid_pop),
    .evt    (mid_evt),
    .cfg    (bcfg_r),
    .res    (back_res)
  );

  irpd_fifo #(
    .WIDTH (ResW),
    .DEPTH (QUEUE_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (mid_pop),
    .wdata (back_res),
    .full  (out_full),
    .pop   (out_pop),
    .rdata (out_rdata),
    .empty (out_empty)
  );

  assign out_servo_duty = out_res.servo_duty;
  assign out_led_duty   = out_res.led_duty;
  assign out_code_done  = out_res.code_done;
  assign out_code_value = out_res.code_value;

`ifndef SYNTHESIS
  a_code_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_code_done) |-> (out_code_value == '0))
    else $error("code value shown without a code");
  a_mid_flow: assert property (@(posedge clk) disable iff (!rst_n)
    (!mid_empty && !out_full) |=> !out_empty)
    else $error("decoded item lost between queues");
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_wr && cfg_idx == irpd_pkg::RegAdjustStep) |=>
    (bcfg_r.adjust_step == $past(cfg_pwdata[3:0])))
    else $error("step register write lost");
`endif

endmodule
`default_nettype wire

// ===== sim/ir_pulse_decoder_duty_stepper_unit_tb.sv =====
// ir_pulse_decoder_duty_stepper_unit_tb: self-checking bench for the ir pulse decoder duty stepper
// feeds edge stamp items and apb register writes, predicts every result item and compares it
// depends on irpd_pkg and ir_pulse_decoder_duty_stepper_unit
module ir_pulse_decoder_duty_stepper_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import irpd_pkg::*;

  localparam int GapMax      = 11;
  localparam int HoldAt      = 200;
  localparam int HoldCycles  = 300;
  localparam int IdleLimit   = 3000;
  localparam int DrainCycles = 6;
  localparam int PhaseItems  = 120;
  localparam int NumPhases   = 8;
  localparam int PrintLimit  = 100;

  typedef enum {IvStart, IvOne, IvZero, IvEqual} iv_kind_e;
  typedef enum {CfgTypical, CfgHigh, CfgLow} cfg_mode_e;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_push = 1'b0;
  logic                in_full;
  logic [15:0]         in_edge_stamp = '0;
  logic                out_empty;
  logic                out_pop = 1'b0;
  logic [7:0]          out_servo_duty;
  logic [8:0]          out_led_duty;
  logic                out_code_done;
  logic [15:0]         out_code_value;
  logic                cfg_psel = 1'b0;
  logic                cfg_penable = 1'b0;
  logic                cfg_pwrite = 1'b0;
  logic [CfgAddrW-1:0] cfg_paddr = '0;
  logic [CfgDataW-1:0] cfg_pwdata = '0;
  logic [CfgDataW-1:0] cfg_prdata;
  logic                cfg_pready;

  ir_pulse_decoder_duty_stepper_unit dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_edge_stamp  (in_edge_stamp),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_servo_duty (out_servo_duty),
    .out_led_duty   (out_led_duty),
    .out_code_done  (out_code_done),
    .out_code_value (out_code_value),
    .cfg_psel       (cfg_psel),
    .cfg_penable    (cfg_penable),
    .cfg_pwrite     (cfg_pwrite),
    .cfg_paddr      (cfg_paddr),
    .cfg_pwdata     (cfg_pwdata),
    .cfg_prdata     (cfg_prdata),
    .cfg_pready     (cfg_pready)
  );

  always #5 clk = ~clk;

  // decoder state and register copies
  front_cfg_t  front_cfg;
  back_cfg_t   back_cfg;
  logic [15:0] last_stamp;
  logic [15:0] shift_bits;
  logic [15:0] latched_code;
  logic [7:0]  bit_count;
  logic [7:0]  servo_level;
  logic [8:0]  led_level;

  logic [15:0] stamp_queue[$];
  result_t     duty_expect[$];
  logic [15:0] gen_stamp = '0;
  int          mismatch_count = 0;
  int          items_checked = 0;
  int          send_gap = 0;
  int          pop_gap = 0;
  int          hold_left = 0;
  int          idle_cycles = 0;
  bit          send_burst = 1'b0;
  bit          pop_burst = 1'b0;

  task automatic reset_decoder();
    front_cfg.start_low     = StartLowRst;
    front_cfg.start_high    = StartHighRst;
    front_cfg.bit_threshold = BitThresholdRst;
    back_cfg.code_servo_up   = CodeServoUpRst;
    back_cfg.code_servo_down = CodeServoDnRst;
    back_cfg.code_led_up     = CodeLedUpRst;
    back_cfg.led_top         = LedTopRst;
    back_cfg.adjust_step     = AdjustStepRst;
    last_stamp   = '0;
    shift_bits   = '0;
    latched_code = '0;
    bit_count    = '0;
    servo_level  = ServoReset;
    led_level    = '0;
  endtask

  function automatic result_t decode_edge(logic [15:0] stamp);
    logic [15:0] interval;
    int          level;
    result_t     r;
    interval = stamp - last_stamp;
    last_stamp = stamp;
    if (interval > front_cfg.start_low && interval < front_cfg.start_high) begin
      latched_code = '0;
      bit_count = '0;
      shift_bits = '0;
    end else if (interval > front_cfg.bit_threshold) begin
      shift_bits = (shift_bits | 16'd1) << 1;
      bit_count = bit_count + 8'd1;
    end else if (interval < front_cfg.bit_threshold) begin
      shift_bits = shift_bits << 1;
      bit_count = bit_count + 8'd1;
    end
    r.code_done = (bit_count == LatchCount);
    r.code_value = '0;
    if (r.code_done) begin
      latched_code = shift_bits;
      r.code_value = latched_code;
      if (latched_code == back_cfg.code_servo_up) begin
        level = servo_level;
        if (level <= ServoMax) level = level + back_cfg.adjust_step;
        if (level > ServoMax) level = ServoMax;
        servo_level = 8'(level);
      end else if (latched_code == back_cfg.code_servo_down) begin
        level = servo_level;
        if (level >= ServoMin)
          level = (level >= back_cfg.adjust_step) ? level - back_cfg.adjust_step : 0;
        if (level < ServoMin) level = ServoMin;
        servo_level = 8'(level);
      end else if (latched_code == back_cfg.code_led_up) begin
        if (led_level <= back_cfg.led_top) led_level = led_level + back_cfg.adjust_step;
      end else if (led_level != '0) begin
        led_level = (led_level >= back_cfg.adjust_step) ? led_level - back_cfg.adjust_step : '0;
      end
    end
    r.servo_duty = servo_level;
    r.led_duty = led_level;
    return r;
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [CfgDataW-1:0] value);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    case (idx)
      RegStartLow:     front_cfg.start_low = value[15:0];
      RegStartHigh:    front_cfg.start_high = value[15:0];
      RegBitThreshold: front_cfg.bit_threshold = value[15:0];
      RegCodeServoUp:  back_cfg.code_servo_up = value[15:0];
      RegCodeServoDn:  back_cfg.code_servo_down = value[15:0];
      RegCodeLedUp:    back_cfg.code_led_up = value[15:0];
      RegLedTop:       back_cfg.led_top = value[7:0];
      RegAdjustStep:   back_cfg.adjust_step = value[3:0];
      default: ;
    endcase
  endtask

  function automatic logic [15:0] random_code();
    return {4'b0, 11'($urandom), 1'b0};
  endfunction

  function automatic bit in_start_window(logic [15:0] iv);
    return iv > front_cfg.start_low && iv < front_cfg.start_high;
  endfunction

  function automatic logic [15:0] pick_interval(iv_kind_e kind);
    logic [15:0] iv;
    int unsigned th;
    int unsigned top;
    int unsigned bottom;
    th = front_cfg.bit_threshold;
    iv = 16'(th);
    for (int n = 0; n < 16; n++) begin
      case (kind)
        IvStart: begin
          if (front_cfg.start_high > front_cfg.start_low + 1)
            iv = 16'($urandom_range(front_cfg.start_low + 1, front_cfg.start_high - 1));
          else
            iv = 16'($urandom);
        end
        IvOne: begin
          if (th == 65535) iv = 16'($urandom);
          else if ($urandom_range(0, 3) == 0) iv = 16'(th + 1);
          else begin
            top = ($urandom_range(0, 3) == 0 || th > 65535 - 60) ? 65535 : th + 60;
            iv = 16'($urandom_range(th + 1, top));
          end
        end
        IvZero: begin
          if (th == 0) iv = 16'($urandom);
          else if ($urandom_range(0, 3) == 0) iv = 16'(th - 1);
          else begin
            bottom = ($urandom_range(0, 3) == 0 || th < 60) ? 0 : th - 60;
            iv = 16'($urandom_range(bottom, th - 1));
          end
        end
        default: iv = 16'(th);
      endcase
      if ((kind == IvStart) == in_start_window(iv)) break;
    end
    return iv;
  endfunction

  task automatic queue_stamp(logic [15:0] stamp);
    gen_stamp = stamp;
    stamp_queue.push_back(stamp);
  endtask

  task automatic queue_interval(logic [15:0] iv);
    queue_stamp(gen_stamp + iv);
  endtask

  task automatic queue_bit();
    queue_interval(pick_interval($urandom_range(0, 1) ? IvOne : IvZero));
  endtask

  // first bit lands in bit 11 of the code
  task automatic queue_frame(logic [15:0] code, bit with_start);
    if (with_start) queue_interval(pick_interval(IvStart));
    for (int k = 11; k >= 1; k--) queue_interval(pick_interval(code[k] ? IvOne : IvZero));
  endtask

  function automatic logic [15:0] pick_target();
    case ($urandom_range(0, 5))
      0:       return back_cfg.code_servo_up;
      1:       return back_cfg.code_servo_down;
      2, 3:    return back_cfg.code_led_up;
      default: return random_code();
    endcase
  endfunction

  task automatic queue_random_items(int count);
    while (stamp_queue.size() < count) begin
      case ($urandom_range(0, 9))
        7: begin
          queue_interval(pick_interval(IvStart));
          repeat ($urandom_range(0, 10)) queue_bit();
        end
        8: repeat ($urandom_range(1, 5)) queue_stamp(16'($urandom));
        9: begin
          repeat ($urandom_range(1, 14)) begin
            if ($urandom_range(0, 4) == 0) queue_interval(pick_interval(IvEqual));
            else queue_bit();
          end
        end
        default: begin
          queue_frame(pick_target(), 1'b1);
          if ($urandom_range(0, 3) == 0) queue_interval(pick_interval(IvEqual));
        end
      endcase
    end
  endtask

  task automatic set_config(cfg_mode_e mode);
    logic [15:0] lo_bound;
    case (mode)
      CfgHigh: begin
        write_reg(RegStartLow, 32'd65533);
        write_reg(RegStartHigh, 32'd65535);
        write_reg(RegBitThreshold, 32'd65535);
        write_reg(RegCodeServoUp, 32'd0);
        write_reg(RegCodeServoDn, 32'hFFFF);
        write_reg(RegCodeLedUp, 32'(random_code()));
        write_reg(RegLedTop, 32'd250);
        write_reg(RegAdjustStep, 32'd15);
      end
      CfgLow: begin
        write_reg(RegStartLow, 32'd0);
        write_reg(RegStartHigh, 32'd2);
        write_reg(RegBitThreshold, 32'd0);
        write_reg(RegCodeServoUp, 32'hFFFF);
        write_reg(RegCodeServoDn, 32'h0FFE);
        write_reg(RegCodeLedUp, 32'd0);
        write_reg(RegLedTop, 32'd0);
        write_reg(RegAdjustStep, 32'd0);
      end
      default: begin
        lo_bound = 16'($urandom_range(10, 400));
        write_reg(RegStartLow, 32'(lo_bound));
        write_reg(RegStartHigh, 32'(lo_bound + $urandom_range(2, 40)));
        write_reg(RegBitThreshold, 32'($urandom_range(1, lo_bound - 1)));
        write_reg(RegCodeServoUp, 32'(random_code()));
        write_reg(RegCodeServoDn, 32'(random_code()));
        write_reg(RegCodeLedUp, 32'(random_code()));
        write_reg(RegLedTop, ($urandom_range(0, 3) == 0) ? 32'd250 : 32'($urandom_range(0, 250)));
        write_reg(RegAdjustStep, ($urandom_range(0, 3) == 0) ? 32'd15 : 32'($urandom_range(1, 15)));
      end
    endcase
  endtask

  task automatic wait_idle();
    while (stamp_queue.size() != 0 || in_push || duty_expect.size() != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
  endtask

  task automatic report_mismatch(string field, logic [15:0] got, logic [15:0] want);
    if (mismatch_count < PrintLimit)
      $display("%0t: %s got 0x%0h want 0x%0h", $time, field, got, want);
    mismatch_count++;
  endtask

  function automatic int draw_gap(bit burst);
    return burst ? 0 : $urandom_range(0, GapMax);
  endfunction

  // edge stamp driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_push && !in_full) begin
        duty_expect.push_back(decode_edge(in_edge_stamp));
        if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
        send_gap = draw_gap(send_burst);
      end
      if (!in_push || !in_full) begin
        if (send_gap > 0) begin
          send_gap--;
          in_push <= 1'b0;
        end else if (stamp_queue.size() != 0) begin
          in_push <= 1'b1;
          in_edge_stamp <= stamp_queue.pop_front();
        end else begin
          in_push <= 1'b0;
        end
      end
    end
  end

  // result monitor and pop control
  always @(posedge clk) begin
    result_t want;
    if (rst_n) begin
      if (out_pop && !out_empty) begin
        if (duty_expect.size() == 0) begin
          report_mismatch("item with nothing expected, code_value", out_code_value, '0);
        end else begin
          want = duty_expect.pop_front();
          if (out_servo_duty !== want.servo_duty)
            report_mismatch("servo_duty", 16'(out_servo_duty), 16'(want.servo_duty));
          if (out_led_duty !== want.led_duty)
            report_mismatch("led_duty", 16'(out_led_duty), 16'(want.led_duty));
          if (out_code_done !== want.code_done)
            report_mismatch("code_done", 16'(out_code_done), 16'(want.code_done));
          if (out_code_value !== want.code_value)
            report_mismatch("code_value", out_code_value, want.code_value);
        end
        items_checked++;
        if (items_checked == HoldAt) hold_left = HoldCycles;
        if ($urandom_range(0, 39) == 0) pop_burst = !pop_burst;
        pop_gap = draw_gap(pop_burst);
      end
      if (hold_left > 0) begin
        hold_left--;
        out_pop <= 1'b0;
      end else if (!out_pop || !out_empty) begin
        if (pop_gap > 0) begin
          pop_gap--;
          out_pop <= 1'b0;
        end else begin
          out_pop <= 1'b1;
        end
      end
    end
  end

  // watchdog on cycles with no handshake
  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty) || cfg_psel) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles == IdleLimit) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    cfg_mode_e mode;
    reset_decoder();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // zero then one from reset, then nine more bits latch an unassigned code
    queue_stamp(16'h0000);
    queue_stamp(16'hFFFF);
    repeat (9) queue_bit();
    queue_frame(back_cfg.code_servo_up, 1'b1);
    queue_interval(pick_interval(IvEqual));
    wait_idle();

    for (int p = 0; p < NumPhases; p++) begin
      mode = (p == 1) ? CfgHigh : (p == 3) ? CfgLow : CfgTypical;
      set_config(mode);
      @(negedge clk);
      if (p == 2) begin
        // long run without a start so the bit count wraps back to a latch
        queue_interval(pick_interval(IvStart));
        repeat (270) queue_bit();
      end
      queue_random_items(stamp_queue.size() + PhaseItems);
      wait_idle();
    end

    if (mismatch_count == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/irpd_pkg.sv
rtl/irpd_fifo.sv
rtl/irpd_front.sv
rtl/irpd_back.sv
rtl/ir_pulse_decoder_duty_stepper_unit.sv
sim/ir_pulse_decoder_duty_stepper_unit_tb.sv
